// ----- rtl/sorted_priority_queue_defines.svh -----
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication whose consequence must hold in the next cycle, outside reset.
`define SPQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// Package with sizes, operation and status codes, and cell control type.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned OCC_W   = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W = 32;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_in;   // insert: open a slot and move values >= the new one up
    logic shift_out;  // remove: move every value down one cell
  } cell_ctrl_t;

endpackage

// ----- rtl/spq_in_if.sv -----
// Input channel: operation and value with valid/ready handshake.
`timescale 1ns / 1ps

interface spq_in_if import spq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 op;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
// Output channel: result value, status and occupancy with valid/ready handshake.
`timescale 1ns / 1ps

interface spq_out_if import spq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  result_value;
  logic [1:0]                 status;
  logic [OCC_W-1:0]           occupancy;

  modport source (output valid, output result_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input result_value, input status, input occupancy,
                  output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// One storage cell of the sorted chain: holds a value and trades with its neighbors.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic                      valid_i,       // cell holds a stored value
  input  logic signed [VALUE_W-1:0] value_i,       // value being inserted
  input  logic                      prev_ge_i,     // lower neighbor is >= value_i
  input  logic signed [VALUE_W-1:0] prev_entry_i,
  input  logic signed [VALUE_W-1:0] next_entry_i,
  output logic                      ge_o,
  output logic signed [VALUE_W-1:0] entry_o
);

  logic signed [VALUE_W-1:0] entry_q, entry_d;

  // flag a stored value that must move up on insert
  assign ge_o    = valid_i && (entry_q >= value_i);
  assign entry_o = entry_q;

  // pick the new content from the neighbors or the inserted value
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in) begin
      if (prev_ge_i) begin
        entry_d = prev_entry_i;
      end else if (ge_o || !valid_i) begin
        entry_d = value_i;
      end
    end else if (ctrl_i.shift_out) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue built from a chain of storage cells.
// Each accepted operation's result is registered in the output register.
// Throughput: one operation per cycle while the output is taken; every cell compares and shifts in the same cycle.
// The output register frees while it is taken, so stalls cost only the stalled cycles.
// Reset clears the count and the output valid; cell contents stay unknown until written.
`timescale 1ns / 1ps

`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  spq_in_if.sink  in_i,
  spq_out_if.source out_o
);

  localparam logic [OCC_W-1:0] DEPTH_C = OCC_W'(DEPTH);

  logic [OCC_W-1:0]          count_q, count_d;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] res_value_q, res_value_d;
  logic [1:0]                res_status_q, res_status_d;
  logic [OCC_W-1:0]          res_occ_q;

  logic                      fire;
  logic                      full;
  logic                      empty;
  cell_ctrl_t                ctrl;

  logic [DEPTH-1:0]          cell_valid;
  logic [DEPTH-1:0]          cell_ge;
  logic signed [VALUE_W-1:0] cell_entry [DEPTH];

  // accept while the output register is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign full       = (count_q == DEPTH_C);
  assign empty      = (count_q == '0);

  // decode the operation into cell commands and the result
  always_comb begin
    ctrl         = '0;
    count_d      = count_q;
    res_value_d  = '0;
    res_status_d = ST_OK;
    unique case (in_i.op)
      OP_INSERT: begin
        if (full) begin
          res_status_d = ST_OVERFLOW;
        end else begin
          ctrl.shift_in = fire;
          count_d       = count_q + OCC_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          res_status_d = ST_UNDERFLOW;
        end else begin
          ctrl.shift_out = fire;
          res_value_d    = cell_entry[0];
          count_d        = count_q - OCC_W'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          res_status_d = ST_UNDERFLOW;
        end else begin
          res_value_d = cell_entry[0];
        end
      end
      default: begin
      end
    endcase
  end

  // build the chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                      prev_ge;
    logic signed [VALUE_W-1:0] prev_entry;
    logic signed [VALUE_W-1:0] next_entry;

    assign cell_valid[g] = (count_q > OCC_W'(g));

    if (g == 0) begin : g_first
      assign prev_ge    = 1'b0;
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_ge    = cell_ge[g-1];
      assign prev_entry = cell_entry[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = cell_entry[g+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (cell_valid[g]),
      .value_i     (in_i.value),
      .prev_ge_i   (prev_ge),
      .prev_entry_i(prev_entry),
      .next_entry_i(next_entry),
      .ge_o        (cell_ge[g]),
      .entry_o     (cell_entry[g])
    );
  end

  // hold count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      out_valid_q <= fire || (out_valid_q && !out_o.ready);
    end
  end

  // capture the result of each accepted transaction
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
      res_occ_q    <= count_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = res_value_q;
  assign out_o.status       = res_status_q;
  assign out_o.occupancy    = res_occ_q;

  `SPQ_ASSERT(a_count_bound, count_q <= DEPTH_C, "count exceeds depth")
  `SPQ_ASSERT(a_head_sorted,
              (count_q < OCC_W'(2)) || (cell_entry[0] <= cell_entry[1]),
              "head cells out of order")
  `SPQ_ASSERT_NEXT(a_overflow, fire && (in_i.op == OP_INSERT) && full,
                   out_o.valid && (out_o.status == ST_OVERFLOW) && (count_q == DEPTH_C),
                   "insert on full queue not flagged")
  `SPQ_ASSERT_NEXT(a_remove_count, fire && (in_i.op == OP_REMOVE) && !empty,
                   count_q == $past(count_q) - OCC_W'(1),
                   "remove did not drop count")

endmodule
